/* src/hlg_pkg.sv */
// shared types and constants for the huber loss and gradient block
`timescale 1ns / 1ps
`default_nettype none

package hlg_pkg;

  // field and register widths
  localparam int DATA_W   = 16;
  localparam int RES_W    = 17;
  localparam int DELTA_W  = 15;
  localparam int INV_W    = 17;
  localparam int GRAD_W   = 32;
  localparam int MEAN_W   = 32;
  localparam int TERM_W   = 33;
  localparam int SUM_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_COUNT = 2'd1;

  // reset values
  localparam logic [DELTA_W-1:0] DELTA_RST     = 15'd256;
  localparam logic [INV_W-1:0]   INV_COUNT_RST = 17'd65536;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_TERM,
    ST_ACC,
    ST_MMUL,
    ST_MEAN,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic step_diff;
    logic step_mul;
    logic step_term;
    logic step_acc;
    logic step_mmul;
    logic step_mean;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

`default_nettype wire

/* src/huber_loss_and_gradient_core.sv */
// Huber loss and gradient: one result per element, mean loss on the last element
//
// Input stream in_*: in_tdata carries prediction and target (signed Q7.8),
// in_tlast marks the final element of a tensor. Output stream out_*: out_tdata
// carries the gradient (signed Q15.16) and the mean loss (unsigned Q16.16),
// out_tuser flags that the mean loss is the finished result.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 delta,
// 1 inv_count); other indexes are ignored. Write only while the block is idle.
// One request at a time runs through a sequencer: after acceptance it passes the
// difference, multiply, term, accumulate and output steps (a last element adds the
// mean multiply and the mean saturation steps). A new request is taken only once
// the previous one has loaded the output register.
// The output register frees the input: the next request can be accepted
// while a result waits; a stalled receiver holds further results at the
// output step until out_tready. Reset (rst_n low, synchronous) clears the
// loss sum, empties the output and restores delta = 1.0, inv_count = 1.0.
`timescale 1ns / 1ps
`default_nettype none

module huber_loss_and_gradient_core
  import hlg_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [31:0]            in_tdata,   // prediction [15:0], target_value [31:16]
  input  wire                    in_tlast,   // last_element
  // output stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [63:0]            out_tdata,  // grad_value [31:0], mean_loss [63:32]
  output logic                   out_tuser   // loss_valid
);

  cmd_t  cmd;
  stat_t stat;
  logic [GRAD_W-1:0] grad_value;
  logic [MEAN_W-1:0] mean_loss;

  // sequencer
  hlg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic and state
  hlg_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .prediction   (in_tdata[15:0]),
    .target_value (in_tdata[31:16]),
    .last_element (in_tlast),
    .cmd          (cmd),
    .stat         (stat),
    .grad_value   (grad_value),
    .mean_loss    (mean_loss),
    .loss_valid   (out_tuser)
  );

  assign out_tdata = {mean_loss, grad_value};

endmodule

`default_nettype wire

/* src/hlg_ctrl.sv */
// controller sequencing one request through the datapath steps
`timescale 1ns / 1ps
`default_nettype none

module hlg_ctrl
  import hlg_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  wire   out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.step_diff = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = ST_TERM;
      end
      ST_TERM: begin
        cmd.step_term = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        cmd.step_acc = 1'b1;
        state_nxt    = stat.last ? ST_MMUL : ST_OUT;
      end
      ST_MMUL: begin
        cmd.step_mmul = 1'b1;
        state_nxt     = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.step_mean = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        // load the output register once it is free or being drained
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

/* src/hlg_datapath.sv */
// datapath: residual, products, loss sum, mean and output register
`timescale 1ns / 1ps
`default_nettype none

module hlg_datapath
  import hlg_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire  [DATA_W-1:0]      prediction,
  input  wire  [DATA_W-1:0]      target_value,
  input  wire                    last_element,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic [GRAD_W-1:0]      grad_value,
  output logic [MEAN_W-1:0]      mean_loss,
  output logic                   loss_valid
);

  // configuration registers
  logic [DELTA_W-1:0] delta_r;
  logic [INV_W-1:0]   inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RST;
      inv_r   <= INV_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELTA:     delta_r <= cfg_data[DELTA_W-1:0];
        REG_INV_COUNT: inv_r   <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic [DATA_W-1:0] pred_r, targ_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pred_r <= prediction;
      targ_r <= target_value;
      last_r <= last_element;
    end
  end

  assign stat.last = last_r;

  // residual, magnitude and branch select
  logic signed [RES_W-1:0] res_nxt, res_r;
  logic [RES_W-1:0]        ares_nxt, ares_r;
  logic                    quad_nxt, quad_r;

  always_comb begin
    res_nxt  = $signed({pred_r[DATA_W-1], pred_r}) - $signed({targ_r[DATA_W-1], targ_r});
    ares_nxt = res_nxt[RES_W-1] ? (~res_nxt + 1'b1) : res_nxt;
    quad_nxt = (ares_nxt <= {2'b00, delta_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.step_diff) begin
      res_r  <= res_nxt;
      ares_r <= ares_nxt;
      quad_r <= quad_nxt;
    end
  end

  // products: term factor, delta squared, gradient
  logic [2*RES_W-1:0]          m1_r;
  logic [2*DELTA_W-1:0]        m2_r;
  logic signed [RES_W+1:0]     gop;
  logic signed [2*RES_W+1:0]   gp_r;
  logic [RES_W-1:0]            m1_op;

  always_comb begin
    m1_op = quad_r ? ares_r : {2'b00, delta_r};
    if (quad_r) begin
      gop = {{2{res_r[RES_W-1]}}, res_r};
    end else if (res_r[RES_W-1]) begin
      gop = -$signed({4'b0000, delta_r});
    end else begin
      gop = $signed({4'b0000, delta_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_mul) begin
      m1_r <= m1_op * ares_r;
      m2_r <= delta_r * delta_r;
      gp_r <= gop * $signed({1'b0, inv_r});
    end
  end

  // term and floored gradient
  logic [TERM_W-1:0] term_r;
  logic [GRAD_W-1:0] grad_r;
  logic [2*RES_W:0]  lin;

  assign lin = {m1_r, 1'b0} - {5'b0, m2_r};

  always_ff @(posedge clk) begin
    if (cmd.step_term) begin
      term_r <= quad_r ? {1'b0, m1_r[TERM_W-2:0]} : lin[TERM_W-1:0];
      grad_r <= {{(GRAD_W-(2*RES_W+2-8)){gp_r[2*RES_W+1]}}, gp_r[2*RES_W+1:8]};
    end
  end

  // running sum, saturating, cleared once the mean product is taken
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W:0]   sum_add;

  assign sum_add = {1'b0, sum_r} + {{(SUM_W+1-TERM_W){1'b0}}, term_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.step_acc) begin
      sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end else if (cmd.step_mmul) begin
      sum_r <= '0;
    end
  end

  // mean: split product of sum and reciprocal
  logic [SUM_W-16+INV_W-1:0] mq_r;
  logic [16+INV_W-1:0]       ml_r;
  logic [SUM_W-16+INV_W-1:0] msum;
  logic [MEAN_W-1:0]         mean_r;

  always_ff @(posedge clk) begin
    if (cmd.step_mmul) begin
      mq_r <= sum_r[SUM_W-1:16] * inv_r;
      ml_r <= sum_r[15:0] * inv_r;
    end
  end

  assign msum = mq_r + {{(SUM_W-16+INV_W-INV_W){1'b0}}, ml_r[16+INV_W-1:16]};

  always_ff @(posedge clk) begin
    if (cmd.step_mean) begin
      mean_r <= (|msum[SUM_W-16+INV_W-1:MEAN_W+1]) ? {MEAN_W{1'b1}} : msum[MEAN_W:1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      grad_value <= grad_r;
      mean_loss  <= last_r ? mean_r : '0;
      loss_valid <= last_r;
    end
  end

endmodule

`default_nettype wire

/* verif/huber_loss_and_gradient_core_test.sv */
// self-checking testbench for the huber loss and gradient core
`timescale 1ns / 1ps

module huber_loss_and_gradient_core_test;
  import hlg_pkg::*;

  localparam int          CYCLE_LIMIT  = 200_000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          PRINT_MAX    = 40;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 166;
  localparam int          SAT_ITEMS    = 16;
  localparam longint      GRAD_MAX     = 64'sd2147483647;
  localparam longint      GRAD_MIN     = -64'sd2147483648;
  localparam longint unsigned SUM_MAX  = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned MEAN_MAX = 64'hFFFF_FFFF;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] pred;
    logic signed [DATA_W-1:0] targ;
    logic                     last;
  } elem_t;

  typedef struct packed {
    logic [GRAD_W-1:0] grad;
    logic [MEAN_W-1:0] mean;
    logic              loss_valid;
  } grad_loss_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // prediction [15:0], target_value [31:16]
  logic                  in_tlast = 1'b0; // last_element
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;       // grad_value [31:0], mean_loss [63:32]
  logic                  out_tuser;       // loss_valid

  // predictor state
  logic [DELTA_W-1:0] huber_delta = DELTA_RST;
  logic [INV_W-1:0]   huber_inv_count = INV_COUNT_RST;
  longint unsigned    loss_acc = 0;

  elem_t      elem_q[$];
  grad_loss_t grad_loss_q[$];
  int         requests_open = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         in_gap_max = 8;
  int         out_stall_max = 8;
  int         in_wait = 0;
  int         out_wait = 0;
  elem_t      in_elem;

  huber_loss_and_gradient_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("huber_loss_and_gradient_core_test failed");
      $finish;
    end
  end

  // gradient, running sum and mean for one element pair
  function automatic grad_loss_t huber_predict(elem_t e);
    longint          resid;
    longint          mag;
    longint          dl;
    longint          inv;
    longint          gprod;
    longint          gq;
    longint unsigned term;
    longint unsigned inv_u;
    longint unsigned mean_full;
    grad_loss_t      res;
    resid = longint'($signed(e.pred)) - longint'($signed(e.targ));
    mag   = (resid < 0) ? -resid : resid;
    dl    = longint'(huber_delta);
    inv   = longint'(huber_inv_count);
    inv_u = longint'(huber_inv_count);
    // quadratic inside the threshold, linear outside
    if (mag <= dl) begin
      term  = mag * mag;
      gprod = resid * inv;
    end else begin
      term  = 2 * dl * mag - dl * dl;
      gprod = (resid < 0) ? -(dl * inv) : dl * inv;
    end
    // floor to Q15.16 and clamp
    gq = gprod >>> 8;
    if (gq > GRAD_MAX) gq = GRAD_MAX;
    if (gq < GRAD_MIN) gq = GRAD_MIN;
    res.grad = gq[GRAD_W-1:0];
    // saturating accumulation
    loss_acc = loss_acc + term;
    if (loss_acc > SUM_MAX) loss_acc = SUM_MAX;
    res.mean = '0;
    res.loss_valid = e.last;
    if (e.last) begin
      mean_full = ((loss_acc >> 16) * inv_u + (((loss_acc & 64'hFFFF) * inv_u) >> 16)) >> 1;
      if (mean_full > MEAN_MAX) mean_full = MEAN_MAX;
      res.mean = mean_full[MEAN_W-1:0];
      loss_acc = 0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint unsigned exp_v, longint unsigned act_v);
    fail_count++;
    if (fail_count <= PRINT_MAX) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        grad_loss_q.push_back(huber_predict(in_elem));
        requests_open--;
      end
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (elem_q.size() > 0) begin
          in_elem = elem_q.pop_front();
          in_tdata <= {in_elem.targ, in_elem.pred};
          in_tlast <= in_elem.last;
          in_tvalid <= 1'b1;
          in_wait = $urandom_range(0, in_gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    grad_loss_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (grad_loss_q.size() == 0) begin
          report_mismatch("unexpected result", 0, out_tdata);
        end else begin
          exp_r = grad_loss_q.pop_front();
          if (out_tdata[31:0] !== exp_r.grad)
            report_mismatch("grad_value", exp_r.grad, out_tdata[31:0]);
          if (out_tdata[63:32] !== exp_r.mean)
            report_mismatch("mean_loss", exp_r.mean, out_tdata[63:32]);
          if (out_tuser !== exp_r.loss_valid)
            report_mismatch("loss_valid", exp_r.loss_valid, out_tuser);
        end
        out_wait = $urandom_range(0, out_stall_max);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_DELTA) huber_delta = value[DELTA_W-1:0];
    else if (idx == REG_INV_COUNT) huber_inv_count = value[INV_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_elem(logic signed [DATA_W-1:0] pred, logic signed [DATA_W-1:0] targ,
                            logic last);
    elem_t e;
    e.pred = pred;
    e.targ = targ;
    e.last = last;
    elem_q.push_back(e);
    requests_open++;
  endtask

  task automatic wait_idle();
    while (requests_open != 0 || grad_loss_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic signed [DATA_W-1:0] tv;
    longint                   off;
    longint                   pv;
    logic [DELTA_W-1:0]       d_sel;
    logic [INV_W-1:0]         inv_sel;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold edges, sign of residual, field extremes
    queue_elem(16'sd0, 16'sd0, 1'b0);
    queue_elem(16'sd256, 16'sd0, 1'b0);
    queue_elem(16'sd257, 16'sd0, 1'b0);
    queue_elem(-16'sd257, 16'sd0, 1'b0);
    queue_elem(-16'sd256, 16'sd0, 1'b0);
    queue_elem(16'sd32767, -16'sd32768, 1'b0);
    queue_elem(-16'sd32768, 16'sd32767, 1'b1);
    queue_elem(16'sd100, 16'sd37, 1'b1);
    wait_idle();

    // reciprocal above one with widest threshold, mean saturates
    write_reg(REG_DELTA, 17'd32767);
    write_reg(REG_INV_COUNT, 17'd131071);
    queue_elem(16'sd32767, -16'sd32768, 1'b0);
    queue_elem(16'sd32767, -16'sd32768, 1'b0);
    queue_elem(16'sd32767, -16'sd32768, 1'b1);
    queue_elem(-16'sd3, 16'sd5, 1'b1);
    wait_idle();

    // zero threshold: zero term and gradient, linear for every nonzero residual
    write_reg(REG_DELTA, 17'd0);
    queue_elem(16'sd5, 16'sd5, 1'b0);
    queue_elem(-16'sd32768, 16'sd32767, 1'b0);
    queue_elem(16'sd7, -16'sd2, 1'b1);
    wait_idle();

    // zero reciprocal
    write_reg(REG_DELTA, 17'd256);
    write_reg(REG_INV_COUNT, 17'd0);
    queue_elem(16'sd100, 16'sd0, 1'b0);
    queue_elem(-16'sd50, 16'sd40, 1'b1);
    wait_idle();

    // out-of-range data bits and writes to unused indexes
    write_reg(REG_DELTA, 17'h1FFFF);
    write_reg(REG_INV_COUNT, 17'd1);
    write_reg(REG_SPARE_A, 17'd5);
    write_reg(REG_SPARE_B, 17'd5);
    queue_elem(16'sd1000, -16'sd1000, 1'b0);
    queue_elem(-16'sd1, 16'sd0, 1'b0);
    queue_elem(16'sd0, 16'sd1, 1'b1);
    wait_idle();

    // random phases over a spread of settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: d_sel = 15'd0;
        1: d_sel = 15'd32767;
        2: d_sel = DELTA_RST;
        default: d_sel = $urandom_range(0, 32767);
      endcase
      case ((p + 1) % 4)
        0: inv_sel = 17'd1;
        1: inv_sel = 17'd131071;
        2: inv_sel = INV_COUNT_RST;
        default: inv_sel = $urandom_range(1, 131071);
      endcase
      write_reg(REG_DELTA, {2'b00, d_sel});
      write_reg(REG_INV_COUNT, inv_sel);
      in_gap_max    = (p % 3 == 1) ? 0 : 8;
      out_stall_max = (p % 4 == 2) ? 0 : 8;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        tv = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) == 0) begin
          // residual close to the threshold
          off = longint'($urandom_range(0, 2 * huber_delta + 2)) - longint'(huber_delta) - 1;
          pv = longint'(tv) + off;
          if (pv > 32767) pv = 32767;
          if (pv < -32768) pv = -32768;
        end else begin
          pv = longint'($signed(16'($urandom_range(0, 65535))));
        end
        queue_elem(pv[DATA_W-1:0], tv, ($urandom_range(0, 9) == 0));
      end
      wait_idle();
    end

    // back-to-back run of largest terms, mean saturates at unit reciprocal
    in_gap_max    = 0;
    out_stall_max = 0;
    write_reg(REG_DELTA, 17'd32767);
    write_reg(REG_INV_COUNT, INV_COUNT_RST);
    for (int k = 0; k < SAT_ITEMS; k++) begin
      queue_elem(16'sd32767, -16'sd32768, 1'b0);
    end
    queue_elem(16'sd0, 16'sd0, 1'b1);
    wait_idle();

    if (fail_count == 0) begin
      $display("huber_loss_and_gradient_core_test passed");
    end else begin
      $display("huber_loss_and_gradient_core_test failed");
    end
    $finish;
  end

endmodule
